// File: hdl/pahp_pkg.sv
// Shared types and constants of the proxy address header parser.
package pahp_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_IPV4_TYPE = 2'd0;
    localparam logic [1:0] REG_HOST_TYPE = 2'd1;
    localparam logic [1:0] REG_IPV6_TYPE = 2'd2;

    // Configuration reset values
    localparam logic [3:0] IPV4_TYPE_RESET = 4'd1;
    localparam logic [3:0] HOST_TYPE_RESET = 4'd3;
    localparam logic [3:0] IPV6_TYPE_RESET = 4'd4;

    // Address kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_IPV4 = 2'd1;
    localparam logic [1:0] KIND_HOST = 2'd2;
    localparam logic [1:0] KIND_IPV6 = 2'd3;

    // Byte roles
    localparam logic [2:0] ROLE_TYPE    = 3'd0;
    localparam logic [2:0] ROLE_HOSTLEN = 3'd1;
    localparam logic [2:0] ROLE_ADDR    = 3'd2;
    localparam logic [2:0] ROLE_PORT    = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
    localparam logic [2:0] ROLE_IGNORED = 3'd5;

    // Parse status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_TYPE  = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // Fixed address lengths
    localparam logic [8:0] IPV4_ADDR_LEN = 9'd4;
    localparam logic [8:0] IPV6_ADDR_LEN = 9'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  address_index;
        logic        header_done;
        logic [8:0]  hdr_total;
        logic [1:0]  address_kind;
        logic [15:0] port_value;
        logic [1:0]  parse_status;
    } out_item_t;

    // Classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [1:0] type_kind;
    } class_item_t;

endpackage

// File: hdl/pahp_front.sv
// Front end: configuration registers and type-nibble classification of each byte.
module pahp_front
    import pahp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  in_item_t    in_data,
    output class_item_t class_item
);

    logic [3:0] ipv4_code_reg;
    logic [3:0] host_code_reg;
    logic [3:0] ipv6_code_reg;
    logic [3:0] nibble;
    logic [1:0] type_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv4_code_reg <= IPV4_TYPE_RESET;
            host_code_reg <= HOST_TYPE_RESET;
            ipv6_code_reg <= IPV6_TYPE_RESET;
        end
        else if (cfg_wen)
        begin
            if (cfg_index == REG_IPV4_TYPE)
            begin
                ipv4_code_reg <= cfg_data;
            end
            if (cfg_index == REG_HOST_TYPE)
            begin
                host_code_reg <= cfg_data;
            end
            if (cfg_index == REG_IPV6_TYPE)
            begin
                ipv6_code_reg <= cfg_data;
            end
        end
    end

    assign nibble = in_data.data_byte[3:0];

    // Host wins over IPv4, IPv4 over IPv6 when codes overlap
    always_comb
    begin
        priority if (nibble == host_code_reg)
        begin
            type_kind = KIND_HOST;
        end
        else if (nibble == ipv4_code_reg)
        begin
            type_kind = KIND_IPV4;
        end
        else if (nibble == ipv6_code_reg)
        begin
            type_kind = KIND_IPV6;
        end
        else
        begin
            type_kind = KIND_NONE;
        end
    end

    assign class_item.data_byte  = in_data.data_byte;
    assign class_item.first_byte = in_data.first_byte;
    assign class_item.last_byte  = in_data.last_byte;
    assign class_item.type_kind  = type_kind;

endmodule

// File: hdl/pahp_queue.sv
// Short FIFO of classified bytes between front and back.
module pahp_queue
    import pahp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  class_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output class_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    class_item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/pahp_back.sv
// Back end: header parse state machine and output register.
module pahp_back
    import pahp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  class_item_t q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    typedef enum logic [6:0] {
        PH_TYPE    = 7'b0000001,
        PH_HOSTLEN = 7'b0000010,
        PH_ADDR    = 7'b0000100,
        PH_PORTHI  = 7'b0001000,
        PH_PORTLO  = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      phase_cur;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic [7:0]  host_len_reg;
    logic [7:0]  host_len_next;
    logic [8:0]  position_reg;
    logic [8:0]  position_next;
    logic [7:0]  port_high_reg;
    logic [7:0]  port_high_next;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    out_item_t   result;
    logic        pending;
    logic [7:0]  addr_start;
    logic [7:0]  addr_idx;
    logic [8:0]  addr_len;
    logic [8:0]  position_inc;

    // Take a byte whenever the output register is free or being emptied
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign phase_cur    = q_item.first_byte ? PH_TYPE : phase_reg;
    assign position_inc = position_reg + 9'd1;
    assign addr_start   = (kind_reg == KIND_HOST) ? 8'd2 : 8'd1;
    assign addr_idx     = position_reg[7:0] - addr_start;

    always_comb
    begin
        unique case (kind_reg)
            KIND_HOST: addr_len = {1'b0, host_len_reg};
            KIND_IPV6: addr_len = IPV6_ADDR_LEN;
            default:   addr_len = IPV4_ADDR_LEN;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_cur;
        kind_next      = kind_reg;
        host_len_next  = host_len_reg;
        position_next  = position_reg;
        port_high_next = port_high_reg;
        pending        = 1'b0;
        result         = '0;

        unique case (phase_cur)
            PH_TYPE:
            begin
                kind_next        = q_item.type_kind;
                host_len_next    = '0;
                port_high_next   = '0;
                position_next    = 9'd1;
                result.byte_role = ROLE_TYPE;
                unique case (q_item.type_kind)
                    KIND_HOST:
                    begin
                        phase_next = PH_HOSTLEN;
                        pending    = 1'b1;
                    end
                    KIND_IPV4, KIND_IPV6:
                    begin
                        phase_next = PH_ADDR;
                        pending    = 1'b1;
                    end
                    default:
                    begin
                        result.parse_status = STATUS_BAD_TYPE;
                        phase_next          = PH_ERROR;
                    end
                endcase
            end
            PH_HOSTLEN:
            begin
                result.byte_role = ROLE_HOSTLEN;
                host_len_next    = q_item.data_byte;
                position_next    = 9'd2;
                phase_next       = (q_item.data_byte == 8'd0) ? PH_PORTHI : PH_ADDR;
                pending          = 1'b1;
            end
            PH_ADDR:
            begin
                result.byte_role     = ROLE_ADDR;
                result.address_index = addr_idx;
                position_next        = position_inc;
                if (({1'b0, addr_idx} + 9'd1) >= addr_len)
                begin
                    phase_next = PH_PORTHI;
                end
                pending = 1'b1;
            end
            PH_PORTHI:
            begin
                result.byte_role = ROLE_PORT;
                port_high_next   = q_item.data_byte;
                position_next    = position_inc;
                phase_next       = PH_PORTLO;
                pending          = 1'b1;
            end
            PH_PORTLO:
            begin
                result.byte_role   = ROLE_PORT;
                position_next      = position_inc;
                result.header_done = 1'b1;
                result.hdr_total   = position_inc;
                result.port_value  = {port_high_reg, q_item.data_byte};
                phase_next         = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                result.byte_role = ROLE_PAYLOAD;
            end
            default:
            begin
                result.byte_role = ROLE_IGNORED;
                phase_next       = PH_ERROR;
            end
        endcase

        // Packet end: flag an unfinished header and expect a type byte next
        if (q_item.last_byte)
        begin
            if (pending)
            begin
                result.parse_status = STATUS_TRUNCATED;
            end
            phase_next = PH_TYPE;
        end

        result.address_kind = kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            kind_reg      <= KIND_NONE;
            host_len_reg  <= '0;
            position_reg  <= '0;
            port_high_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                kind_reg      <= kind_next;
                host_len_reg  <= host_len_next;
                position_reg  <= position_next;
                port_high_reg <= port_high_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// File: hdl/proxy_address_header_parser_top.sv
// Proxy address header parser: parses a destination header one byte per item.
//
// Input channel in_valid/in_ready/in_data carries one packet byte per item with
// first/last marks. Output channel out_valid/out_ready/out_data returns exactly
// one result item per input item, in order: the byte's role, address index,
// and on the byte that completes a header its length, kind and port.
// Type codes are set through cfg_wen/cfg_index/cfg_data. The user must set them only
// while the block is idle; the block itself does not enforce this.
// An accepted byte is registered in the queue, and the parse stage pops it and
// loads its result into the output register. Throughput: one byte per cycle
// while the receiver does not stall. The front classifies each byte's type
// nibble and pushes it into a queue of QUEUE_DEPTH entries; the back pops one
// entry a cycle while its output register is free or being emptied.
// When the receiver stalls, the output register holds its item, the back stops
// popping, and in_ready drops once the queue is full.
// Reset empties the queue and output register, restores the default type codes
// (IPv4 1, host 3, IPv6 4) and leaves the parser expecting a type byte.
module proxy_address_header_parser_top
    import pahp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_wen,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    class_item_t class_item;
    class_item_t q_item;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    logic        push;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    pahp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_data    (in_data),
        .class_item (class_item)
    );

    pahp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (class_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    pahp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Testbench of the proxy address header parser: directed headers, then random packet traffic.
module testbench;
    import pahp_pkg::*;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_HOSTLEN,
        PH_ADDR,
        PH_PORTHI,
        PH_PORTLO,
        PH_PAYLOAD,
        PH_ERROR
    } parse_phase_t;

    localparam int PKT_WELL    = 0;
    localparam int PKT_UNKNOWN = 1;
    localparam int PKT_NOISE   = 2;
    localparam int PKT_LONG    = 3;

    localparam int PHASE_ITEMS = 238;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_wen = 1'b0;
    logic [1:0] cfg_index = REG_IPV4_TYPE;
    logic [3:0] cfg_data = '0;

    // Parser state as predicted
    logic [3:0]   v4_code = IPV4_TYPE_RESET;
    logic [3:0]   host_code = HOST_TYPE_RESET;
    logic [3:0]   v6_code = IPV6_TYPE_RESET;
    parse_phase_t phase = PH_TYPE;
    logic [1:0]   kind_now = KIND_NONE;
    logic [7:0]   name_len = '0;
    logic [8:0]   hdr_pos = '0;
    logic [7:0]   port_hi = '0;

    out_item_t   expected_results[$];
    logic [7:0]  pkt[$];
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          fail_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          done_count[4] = '{0, 0, 0, 0};
    int          bad_type_count = 0;
    int          truncated_count = 0;
    int          settings_count = 0;

    proxy_address_header_parser_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Host name wins over IPv4, IPv4 over IPv6
    function automatic logic [1:0] kind_of(logic [3:0] nib);
        if (nib == host_code)
            return KIND_HOST;
        if (nib == v4_code)
            return KIND_IPV4;
        if (nib == v6_code)
            return KIND_IPV6;
        return KIND_NONE;
    endfunction

    function automatic out_item_t decode_byte(in_item_t b);
        out_item_t  r;
        logic       open_hdr;
        logic [8:0] alen;
        logic [8:0] start;
        r = '0;
        open_hdr = 1'b0;
        if (b.first_byte)
            phase = PH_TYPE;
        case (phase)
            PH_TYPE:
            begin
                kind_now = kind_of(b.data_byte[3:0]);
                name_len = '0;
                port_hi = '0;
                hdr_pos = 9'd1;
                r.byte_role = ROLE_TYPE;
                if (kind_now == KIND_NONE)
                begin
                    r.parse_status = STATUS_BAD_TYPE;
                    phase = PH_ERROR;
                end
                else
                begin
                    open_hdr = 1'b1;
                    phase = (kind_now == KIND_HOST) ? PH_HOSTLEN : PH_ADDR;
                end
            end
            PH_HOSTLEN:
            begin
                r.byte_role = ROLE_HOSTLEN;
                name_len = b.data_byte;
                hdr_pos = 9'd2;
                phase = (b.data_byte == 8'd0) ? PH_PORTHI : PH_ADDR;
                open_hdr = 1'b1;
            end
            PH_ADDR:
            begin
                start = (kind_now == KIND_HOST) ? 9'd2 : 9'd1;
                if (kind_now == KIND_HOST)
                    alen = {1'b0, name_len};
                else if (kind_now == KIND_IPV6)
                    alen = IPV6_ADDR_LEN;
                else
                    alen = IPV4_ADDR_LEN;
                r.byte_role = ROLE_ADDR;
                r.address_index = 8'(hdr_pos - start);
                hdr_pos = hdr_pos + 9'd1;
                if ({1'b0, r.address_index} + 9'd1 >= alen)
                    phase = PH_PORTHI;
                open_hdr = 1'b1;
            end
            PH_PORTHI:
            begin
                r.byte_role = ROLE_PORT;
                port_hi = b.data_byte;
                hdr_pos = hdr_pos + 9'd1;
                phase = PH_PORTLO;
                open_hdr = 1'b1;
            end
            PH_PORTLO:
            begin
                r.byte_role = ROLE_PORT;
                hdr_pos = hdr_pos + 9'd1;
                r.header_done = 1'b1;
                r.hdr_total = hdr_pos;
                r.port_value = {port_hi, b.data_byte};
                phase = PH_PAYLOAD;
            end
            PH_PAYLOAD:
                r.byte_role = ROLE_PAYLOAD;
            default:
            begin
                r.byte_role = ROLE_IGNORED;
                phase = PH_ERROR;
            end
        endcase
        if (b.last_byte)
        begin
            if (open_hdr)
                r.parse_status = STATUS_TRUNCATED;
            phase = PH_TYPE;
        end
        r.address_kind = kind_now;
        return r;
    endfunction

    // Mostly short waits, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else
            stall_left = pick_gap();
        out_ready <= (stall_left == 0);
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with no byte waiting for it");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_seen++;
                if (want.header_done)
                    done_count[want.address_kind]++;
                if (want.parse_status == STATUS_BAD_TYPE)
                    bad_type_count++;
                if (want.parse_status == STATUS_TRUNCATED)
                    truncated_count++;
                if (out_data.byte_role !== want.byte_role)
                begin
                    $error("byte_role: expected %0d, got %0d", want.byte_role,
                           out_data.byte_role);
                    fail_count++;
                end
                if (out_data.address_index !== want.address_index)
                begin
                    $error("address_index: expected %0d, got %0d", want.address_index,
                           out_data.address_index);
                    fail_count++;
                end
                if (out_data.header_done !== want.header_done)
                begin
                    $error("header_done: expected %0d, got %0d", want.header_done,
                           out_data.header_done);
                    fail_count++;
                end
                if (out_data.hdr_total !== want.hdr_total)
                begin
                    $error("hdr_total: expected %0d, got %0d", want.hdr_total,
                           out_data.hdr_total);
                    fail_count++;
                end
                if (out_data.address_kind !== want.address_kind)
                begin
                    $error("address_kind: expected %0d, got %0d", want.address_kind,
                           out_data.address_kind);
                    fail_count++;
                end
                if (out_data.port_value !== want.port_value)
                begin
                    $error("port_value: expected %0h, got %0h", want.port_value,
                           out_data.port_value);
                    fail_count++;
                end
                if (out_data.parse_status !== want.parse_status)
                begin
                    $error("parse_status: expected %0d, got %0d", want.parse_status,
                           out_data.parse_status);
                    fail_count++;
                end
            end
        end
    end

    // Hold valid and payload until the item is taken, then predict its result
    task automatic send_byte(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.insert(expected_results.size(), decode_byte(it));
        items_sent++;
    endtask

    task automatic send_pkt(input bit mark, input bit close);
        in_item_t it;
        for (int i = 0; i < pkt.size(); i++)
        begin
            it.data_byte = pkt[i];
            it.first_byte = (i == 0) && mark;
            it.last_byte = (i == pkt.size() - 1) && close;
            send_byte(it);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_codes(input logic [3:0] v4, input logic [3:0] host,
                              input logic [3:0] v6);
        wait_all_results();
        cfg_wen <= 1'b1;
        cfg_index <= REG_IPV4_TYPE;
        cfg_data <= v4;
        @(posedge clk);
        cfg_index <= REG_HOST_TYPE;
        cfg_data <= host;
        @(posedge clk);
        cfg_index <= REG_IPV6_TYPE;
        cfg_data <= v6;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        v4_code = v4;
        host_code = host;
        v6_code = v6;
        settings_count++;
    endtask

    task automatic send_packet(input int style);
        logic [3:0] nib;
        logic [1:0] k;
        int         addr_n;
        int         n;
        int         pick;
        bit         mark;
        bit         close;
        in_item_t   it;
        pkt.delete();
        mark = ($urandom_range(0, 9) != 0);
        close = ($urandom_range(0, 9) != 0);
        if (style == PKT_LONG)
            mark = 1'b1;
        if (style == PKT_NOISE)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                it.data_byte = 8'($urandom);
                it.first_byte = 1'($urandom);
                it.last_byte = 1'($urandom);
                send_byte(it);
            end
            return;
        end
        pick = $urandom_range(0, 2);
        if (style == PKT_UNKNOWN)
            nib = 4'($urandom);
        else if (style == PKT_LONG || pick == 1)
            nib = host_code;
        else if (pick == 0)
            nib = v4_code;
        else
            nib = v6_code;
        k = kind_of(nib);
        pkt.insert(pkt.size(), {4'($urandom), nib});
        addr_n = 0;
        if (k == KIND_HOST)
        begin
            addr_n = (style == PKT_LONG) ? 255 : $urandom_range(0, 12);
            pkt.insert(pkt.size(), 8'(addr_n));
        end
        else if (k == KIND_IPV6)
            addr_n = 16;
        else if (k == KIND_IPV4)
            addr_n = 4;
        if (k != KIND_NONE)
            repeat (addr_n + 2) pkt.insert(pkt.size(), 8'($urandom));
        repeat ($urandom_range(0, 4)) pkt.insert(pkt.size(), 8'($urandom));
        // Cut the packet short now and then, but keep the long host name whole
        if (style != PKT_LONG && pkt.size() > 1 && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > n)
                void'(pkt.pop_back());
            close = 1'b1;
        end
        send_pkt(mark, close);
    endtask

    task automatic test_ipv4_header();
        // High type nibble must be ignored
        pkt = '{8'hF1, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hFF, 8'h5A};
        send_pkt(1'b1, 1'b1);
    endtask

    task automatic test_empty_host();
        pkt = '{8'h03, 8'h00, 8'h00, 8'h00};
        send_pkt(1'b1, 1'b1);
    endtask

    task automatic test_truncation();
        pkt = '{8'h03, 8'h05, 8'h61};
        send_pkt(1'b1, 1'b1);
        pkt = '{8'h04};
        send_pkt(1'b1, 1'b1);
    endtask

    task automatic test_restart_and_unknown();
        // Open header abandoned by a new packet mark that carries an unknown type
        pkt = '{8'h01, 8'h0A};
        send_pkt(1'b1, 1'b0);
        pkt = '{8'h0E, 8'h42};
        send_pkt(1'b1, 1'b1);
        // Type byte without the mark right after a packet end
        pkt = '{8'h21};
        send_pkt(1'b0, 1'b1);
    endtask

    task automatic test_code_priority();
        load_codes(4'd7, 4'd7, 4'd7);
        pkt = '{8'h07};
        send_pkt(1'b1, 1'b1);
        load_codes(4'd9, HOST_TYPE_RESET, 4'd9);
        pkt = '{8'h09};
        send_pkt(1'b1, 1'b1);
    endtask

    task automatic test_random_traffic();
        int  start;
        int  r;
        bit  paused;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: load_codes(IPV4_TYPE_RESET, HOST_TYPE_RESET, IPV6_TYPE_RESET);
                1: load_codes(4'd0, 4'd15, 4'd8);
                2: load_codes(4'd15, 4'd0, 4'd15);
                5: load_codes(IPV4_TYPE_RESET, HOST_TYPE_RESET, IPV6_TYPE_RESET);
                default: load_codes(4'($urandom), 4'($urandom), 4'($urandom));
            endcase
            start = items_sent;
            paused = 1'b0;
            if (p == 1)
                send_packet(PKT_LONG);
            while (items_sent - start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 19) == 0)
                    quiet = !quiet;
                r = $urandom_range(0, 99);
                if (r < 78)
                    send_packet(PKT_WELL);
                else if (r < 90)
                    send_packet(PKT_UNKNOWN);
                else
                    send_packet(PKT_NOISE);
                // Hold off the sender until the parser has drained
                if (!paused && items_sent - start > PHASE_ITEMS / 2)
                begin
                    wait_all_results();
                    paused = 1'b1;
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ipv4_header();
        test_empty_host();
        test_truncation();
        test_restart_and_unknown();
        test_code_priority();
        test_random_traffic();
        wait_all_results();
        $display("Checked %0d result items: %0d IPv4, %0d host and %0d IPv6 headers done,",
                 results_seen, done_count[KIND_IPV4], done_count[KIND_HOST],
                 done_count[KIND_IPV6]);
        $display("%0d bad types, %0d truncations, %0d type code settings, one 255-byte host",
                 bad_type_count, truncated_count, settings_count);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
